[sv/lzsswd_pkg.sv]
// lzsswd_pkg: shared constants and types for the LZSS window decompressor.
// No dependencies; imported by lzsswd_window, lzss_window_decompressor_top and the bench.
package lzsswd_pkg;

   localparam int WIN_AW    = 12;
   localparam int WIN_DEPTH = 4096;
   localparam int FILL_W    = WIN_AW + 1;

   localparam logic [WIN_AW-1:0] WPOS_RESET = 12'hfee;
   localparam logic [FILL_W-1:0] FILL_FULL  = 13'd4096;

   // parse phases
   localparam logic [1:0] PH_FLAG     = 2'd0;
   localparam logic [1:0] PH_LITERAL  = 2'd1;
   localparam logic [1:0] PH_OFF_LOW  = 2'd2;
   localparam logic [1:0] PH_OFF_HIGH = 2'd3;

   localparam logic [8:0] FLAG_MARK = 9'h100;

   // match length minus one is nibble + 2
   localparam logic [4:0] MATCH_EXTRA = 5'd2;

   typedef struct packed {
      logic clear;
      logic wr_en;
      logic rd_en;
   } win_ctl_type;

endpackage

[sv/lzsswd_window.sv]
// lzsswd_window: 4096-byte history window with write pointer and fill count.
// Depends on lzsswd_pkg. Entries not written since the last clear read as zero.
module lzsswd_window
   import lzsswd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  win_ctl_type       ctl,
   input  logic [7:0]        wr_data,
   input  logic [WIN_AW-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0]        mem [WIN_DEPTH];
   logic [WIN_AW-1:0] wpos_ff, wpos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        rd_data_ff;
   logic              rd_valid_ff, rd_valid_in;
   logic [WIN_AW-1:0] rd_off;

   // distance of the read address from the stream's first write slot
   assign rd_off      = rd_addr - WPOS_RESET;
   assign rd_valid_in = {1'b0, rd_off} < fill_ff;

   always_comb begin
      wpos_in = wpos_ff;
      fill_in = fill_ff;
      if (ctl.clear) begin
         wpos_in = WPOS_RESET;
         fill_in = '0;
      end else if (ctl.wr_en) begin
         wpos_in = wpos_ff + 1'b1;
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff     <= WPOS_RESET;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         wpos_ff <= wpos_in;
         fill_ff <= fill_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= rd_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wpos_ff] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'h00;

   a_no_wr_on_clear: assert property (@(posedge clock) disable iff (reset)
      !(ctl.clear && ctl.wr_en))
      else $error("window write during clear");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count past window size");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_en && !ctl.clear && fill_ff != FILL_FULL) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill count missed a write");

endmodule

[sv/lzss_window_decompressor_top.sv]
// lzss_window_decompressor_top: LZSS decompressor with a 4096-byte window.
// Depends on lzsswd_pkg and lzsswd_window.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  req     | in        | req_valid/req_stall | data_byte, stream_start, out_length
//  rsp     | out       | rsp_valid/rsp_stall | out_byte, last_of_run, stream_done
//
// Flow: one item at a time; req_stall holds off a new item until the last is done.
// A match second byte then reads and emits its n copied bytes in turn (n = 3..18).
// Each copied byte takes a window read state and then an emit/write state on the single
// window port pair, so overlapping copies see the byte written just before.
// Reset: synchronous, active high; window needs no clearing pass, a fill count marks
// written entries and unwritten ones read as zero. Stream start restarts it at once.
// Stalls: a result item waits in the output register; emission pauses while it is held.
module lzss_window_decompressor_top
   import lzsswd_pkg::*;
#(
   parameter int LENGTH_BITS = 24
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   input  logic [23:0] req_out_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_stream_done
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROC  = 2'd1;
   localparam logic [1:0] ST_MREAD = 2'd2;
   localparam logic [1:0] ST_MDATA = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [7:0]             byte_ff, byte_in;
   logic [8:0]             ctrl_ff, ctrl_in;
   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             off_low_ff, off_low_in;
   logic [LENGTH_BITS-1:0] produced_ff, produced_in;
   logic [LENGTH_BITS-1:0] target_ff, target_in;
   logic [WIN_AW-1:0]      ptr_ff, ptr_in;     // copy read pointer
   logic [4:0]             rem_ff, rem_in;     // bytes left after the current one

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_done_ff, rsp_done_in;

   win_ctl_type            win_ctl;
   logic [7:0]             win_wr_data;
   logic [7:0]             win_rd_data;

   logic                   accept;
   logic                   slot_free;
   logic [LENGTH_BITS-1:0] produced_inc;
   logic                   hit_target;
   logic [8:0]             ctrl_shift;
   logic [1:0]             phase_adv;

   assign accept       = req_valid && !req_stall;
   assign req_stall    = state_ff != ST_IDLE;
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign produced_inc = produced_ff + 1'b1;
   assign hit_target   = produced_inc == target_ff;

   // next flag bit; a lone marker means a fresh flag byte is due
   assign ctrl_shift = {1'b0, ctrl_ff[8:1]};
   assign phase_adv  = (ctrl_shift <= 9'd1) ? PH_FLAG :
                       (ctrl_shift[0] ? PH_LITERAL : PH_OFF_LOW);

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      ctrl_in      = ctrl_ff;
      phase_in     = phase_ff;
      off_low_in   = off_low_ff;
      produced_in  = produced_ff;
      target_in    = target_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      win_ctl      = '0;
      win_wr_data  = byte_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in  = req_data_byte;
               state_in = ST_PROC;
               if (req_stream_start) begin
                  win_ctl.clear = 1'b1;
                  ctrl_in       = '0;
                  phase_in      = PH_FLAG;
                  off_low_in    = '0;
                  produced_in   = '0;
                  target_in     = LENGTH_BITS'(req_out_length);
               end
            end
         end
         ST_PROC: begin
            if (produced_ff == target_ff) begin
               // stream complete or never started: byte is dropped
               state_in = ST_IDLE;
            end else begin
               case (phase_ff)
                  PH_FLAG: begin
                     ctrl_in  = {1'b0, byte_ff} | FLAG_MARK;
                     phase_in = byte_ff[0] ? PH_LITERAL : PH_OFF_LOW;
                     state_in = ST_IDLE;
                  end
                  PH_LITERAL: begin
                     if (slot_free) begin
                        win_ctl.wr_en = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = byte_ff;
                        rsp_last_in   = 1'b1;
                        rsp_done_in   = hit_target;
                        produced_in   = produced_inc;
                        ctrl_in       = ctrl_shift;
                        phase_in      = phase_adv;
                        state_in      = ST_IDLE;
                     end
                  end
                  PH_OFF_LOW: begin
                     off_low_in = byte_ff;
                     phase_in   = PH_OFF_HIGH;
                     state_in   = ST_IDLE;
                  end
                  default: begin
                     ptr_in   = {byte_ff[7:4], off_low_ff};
                     rem_in   = {1'b0, byte_ff[3:0]} + MATCH_EXTRA;
                     state_in = ST_MREAD;
                  end
               endcase
            end
         end
         ST_MREAD: begin
            win_ctl.rd_en = 1'b1;
            state_in      = ST_MDATA;
         end
         ST_MDATA: begin
            if (slot_free) begin
               win_ctl.wr_en = 1'b1;
               win_wr_data   = win_rd_data;
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = win_rd_data;
               rsp_last_in   = hit_target || rem_ff == 5'd0;
               rsp_done_in   = hit_target;
               produced_in   = produced_inc;
               if (hit_target || rem_ff == 5'd0) begin
                  // match finished or cut short at the expected length
                  ctrl_in  = ctrl_shift;
                  phase_in = phase_adv;
                  state_in = ST_IDLE;
               end else begin
                  rem_in   = rem_ff - 1'b1;
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = ST_MREAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctrl_ff      <= '0;
         phase_ff     <= PH_FLAG;
         off_low_ff   <= '0;
         produced_ff  <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_ff      <= ctrl_in;
         phase_ff     <= phase_in;
         off_low_ff   <= off_low_in;
         produced_ff  <= produced_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      ptr_ff      <= ptr_in;
      rem_ff      <= rem_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   lzsswd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .wr_data (win_wr_data),
      .rd_addr (ptr_ff),
      .rd_data (win_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

   a_produced_bound: assert property (@(posedge clock) disable iff (reset)
      produced_ff <= target_ff)
      else $error("output count passed expected length");

   a_write_emits: assert property (@(posedge clock) disable iff (reset)
      win_ctl.wr_en |=> rsp_valid_ff)
      else $error("window write without a result item");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff)
      else $error("stream done not marked last of run");

endmodule

[sim/lzss_window_decompressor_top_tb.sv]
// lzss_window_decompressor_top_tb: self-checking bench for the LZSS window decompressor.
// Runs a directed stimulus table and then random streams, checking every output byte.
// Depends on lzsswd_pkg and lzss_window_decompressor_top.
`timescale 1ns / 100ps

module lzss_window_decompressor_top_tb
   import lzsswd_pkg::*;
;

   localparam int RANDOM_ITEMS = 450;   // consumed (non-ignored) input items
   localparam int DRAIN_CYCLES = 64;    // settle time after the last output byte
   localparam int HANG_LIMIT   = 4000;  // cycles without any handshake
   localparam int MAX_RUN      = 18;    // most output bytes one input item can cause

   // Receiver stall behaviors
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   // One decompressed output item
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
   } out_item_type;

   // One row of the directed table; typed rows carry their expected output
   typedef struct packed {
      logic [7:0]  data;
      logic        start;
      logic [23:0] len;
      logic        typed;
      logic        has_out;
      logic [7:0]  out_data;
      logic        out_done;
   } dir_row_type;

   localparam int DIR_ROWS = 23;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte    = 8'h00;
   logic        req_stream_start = 1'b0;
   logic [23:0] req_out_length   = 24'd0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        rsp_stream_done;

   // Decoder shadow state
   logic [7:0]  hist_mem [WIN_DEPTH];
   logic [11:0] wr_pos;
   logic [8:0]  flag_bits;
   logic [1:0]  phase;
   logic [7:0]  off_low;
   logic [23:0] produced;
   logic [23:0] target;

   // Bytes one input item produces, before they go to the pending queue
   out_item_type run_buf [MAX_RUN];
   int           run_len;

   out_item_type pending_bytes [$];
   int           fail_count = 0;

   // Sender burst and random stream generator state
   int          burst_left = 0;
   int          strm_left  = 0;
   int          post_left  = 0;
   logic [3:0]  src_hi     = 4'd0;

   // Receiver stall pattern state
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_cyc  = 0;
   int             idle_cycles = 0;

   // Directed table. Typed rows hold results readable at a glance; the rest
   // (matches) go through the shadow decoder.
   dir_row_type dir_rows [DIR_ROWS] = '{
      // bytes before any stream start are dropped
      '{8'h55, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      // zero-length stream: everything ignored
      '{8'hff, 1'b1, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      '{8'h12, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      // max length; flag = one literal then matches
      '{8'h01, 1'b1, 24'hffffff,  1'b1, 1'b0, 8'h00, 1'b0},
      '{8'h00, 1'b0, 24'd0,       1'b1, 1'b1, 8'h00, 1'b0},
      // match at window start position, length 18, overlapping the write pointer
      '{8'hee, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      '{8'hff, 1'b0, 24'd0,       1'b0, 1'b0, 8'h00, 1'b0},
      // match at position 0, shortest length
      '{8'h00, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      '{8'h00, 1'b0, 24'd0,       1'b0, 1'b0, 8'h00, 1'b0},
      // match at the top of the window, wraps to 0
      '{8'hff, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      '{8'hf0, 1'b0, 24'd0,       1'b0, 1'b0, 8'h00, 1'b0},
      // all-literal stream of five bytes, then a byte after completion
      '{8'hff, 1'b1, 24'd5,       1'b1, 1'b0, 8'h00, 1'b0},
      '{8'hff, 1'b0, 24'd0,       1'b1, 1'b1, 8'hff, 1'b0},
      '{8'h80, 1'b0, 24'd0,       1'b1, 1'b1, 8'h80, 1'b0},
      '{8'h7f, 1'b0, 24'd0,       1'b1, 1'b1, 8'h7f, 1'b0},
      '{8'h01, 1'b0, 24'd0,       1'b1, 1'b1, 8'h01, 1'b0},
      '{8'h5a, 1'b0, 24'd0,       1'b1, 1'b1, 8'h5a, 1'b1},
      '{8'h33, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      // length-18 match cut short at a length of four
      '{8'hfe, 1'b1, 24'd4,       1'b1, 1'b0, 8'h00, 1'b0},
      '{8'hee, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      '{8'hff, 1'b0, 24'd0,       1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h44, 1'b0, 24'd0,       1'b1, 1'b0, 8'h00, 1'b0},
      // single-byte stream: its flag byte, the random part carries on from here
      '{8'h01, 1'b1, 24'd1,       1'b1, 1'b0, 8'h00, 1'b0}
   };

   lzss_window_decompressor_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_stream_start (req_stream_start),
      .req_out_length   (req_out_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_stream_done  (rsp_stream_done)
   );

   always #1 clock = ~clock;

   // Append one byte to the current run, write it back to the window.
   // Returns 1 once the stream has reached its expected length.
   function automatic bit emit_byte(input logic [7:0] b);
      produced = produced + 24'd1;
      run_buf[run_len] = '{b, 1'b0, produced == target};
      run_len++;
      hist_mem[wr_pos] = b;
      wr_pos = wr_pos + 12'd1;
      return produced == target;
   endfunction

   // Pull the next flag bit; a lone marker bit means a new flag byte is due.
   function automatic void next_flag_bit();
      flag_bits = flag_bits >> 1;
      if (flag_bits <= 9'd1)
         phase = PH_FLAG;
      else
         phase = flag_bits[0] ? PH_LITERAL : PH_OFF_LOW;
   endfunction

   // Shadow decoder: consume one compressed byte; queue its output bytes when keep is set.
   task automatic decode_byte(input logic [7:0] din, input logic start,
                              input logic [23:0] len, input bit keep, output bit ignored);
      logic [11:0] pos;
      int          cnt;
      run_len = 0;
      if (start) begin
         for (int i = 0; i < WIN_DEPTH; i++)
            hist_mem[i] = 8'h00;
         wr_pos    = WPOS_RESET;
         flag_bits = 9'd0;
         phase     = PH_FLAG;
         off_low   = 8'h00;
         produced  = 24'd0;
         target    = len;
      end
      ignored = (produced == target);
      if (!ignored) begin
         case (phase)
            PH_FLAG: begin
               flag_bits = FLAG_MARK | {1'b0, din};
               phase     = din[0] ? PH_LITERAL : PH_OFF_LOW;
            end
            PH_LITERAL: begin
               void'(emit_byte(din));
               next_flag_bit();
            end
            PH_OFF_LOW: begin
               off_low = din;
               phase   = PH_OFF_HIGH;
            end
            default: begin
               pos = {din[7:4], off_low};
               cnt = int'(din[3:0]) + 3;
               for (int i = 0; i < cnt; i++) begin
                  if (emit_byte(hist_mem[pos + 12'(i)]))
                     break;
               end
               next_flag_bit();
            end
         endcase
      end
      if (keep && run_len > 0) begin
         run_buf[run_len-1].last = 1'b1;
         for (int i = 0; i < run_len; i++)
            pending_bytes.push_back(run_buf[i]);
      end
   endtask

   // Sender: bursts of random length, random gaps between bursts.
   // Returns at the edge where the item is taken.
   task automatic send_item(input logic [7:0] d, input logic s, input logic [23:0] l);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_data_byte    <= d;
      req_stream_start <= s;
      req_out_length   <= l;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
   endtask

   // Random stream generator. Mostly well-formed streams: flag bytes, literals and
   // matches that point a short way back into the window, so copies hit real data.
   // A few noise bytes, mid-stream restarts and bytes after completion mixed in.
   task automatic pick_random_item(output logic [7:0] d, output logic s,
                                   output logic [23:0] l);
      logic [11:0] src;
      int          pick;
      s    = 1'b0;
      l    = 24'($urandom);
      d    = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (strm_left == 0 || (produced == target && post_left == 0) || pick == 0) begin
         s = 1'b1;
         case ($urandom_range(0, 9))
            0:       l = 24'd0;
            1:       l = 24'($urandom);
            default: l = 24'($urandom_range(1, 150));
         endcase
         strm_left = $urandom_range(16, 90);
         post_left = $urandom_range(0, 3);
      end else if (produced == target) begin
         post_left--;
      end else begin
         strm_left--;
         if (pick >= 8) begin
            case (phase)
               PH_OFF_LOW: begin
                  if (pick < 30)
                     src = 12'($urandom);
                  else
                     src = wr_pos - 12'($urandom_range(1, 48));
                  d      = src[7:0];
                  src_hi = src[11:8];
               end
               PH_OFF_HIGH: d = {src_hi, 4'($urandom)};
               default: ;
            endcase
         end
      end
   endtask

   // Receiver stall pattern: the mode is redrawn at random and drives rsp_stall
   always @(posedge clock) begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 80 == 0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_stall <= (stall_cyc % 7) < 3;
         default:        rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
      endcase
   end

   // Output check: each taken byte against the oldest pending one
   always @(posedge clock) begin : rsp_check
      out_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            fail_count++;
            $display("%0t: output byte %02h with nothing pending", $time, rsp_out_byte);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               fail_count++;
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want.data, rsp_out_byte);
            end
            if (rsp_last_of_run !== want.last) begin
               fail_count++;
               $display("%0t: last_of_run expected %0b actual %0b",
                        $time, want.last, rsp_last_of_run);
            end
            if (rsp_stream_done !== want.done) begin
               fail_count++;
               $display("%0t: stream_done expected %0b actual %0b",
                        $time, want.done, rsp_stream_done);
            end
         end
      end
   end

   // Hang detector: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int          used_items;
      logic [7:0]  d;
      logic        s;
      logic [23:0] l;
      bit          ignored;

      used_items = 0;
      // shadow state matches the block after reset
      for (int i = 0; i < WIN_DEPTH; i++)
         hist_mem[i] = 8'h00;
      wr_pos    = WPOS_RESET;
      flag_bits = 9'd0;
      phase     = PH_FLAG;
      off_low   = 8'h00;
      produced  = 24'd0;
      target    = 24'd0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: typed rows queue their written-in result, the rest the decoder's
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_item(dir_rows[i].data, dir_rows[i].start, dir_rows[i].len);
         decode_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].len,
                     !dir_rows[i].typed, ignored);
         if (dir_rows[i].typed && dir_rows[i].has_out)
            pending_bytes.push_back('{dir_rows[i].out_data, 1'b1, dir_rows[i].out_done});
      end

      // random streams; ignored bytes do not count
      while (used_items < RANDOM_ITEMS) begin
         pick_random_item(d, s, l);
         send_item(d, s, l);
         decode_byte(d, s, l, 1'b1, ignored);
         if (!ignored)
            used_items++;
      end
      req_valid <= 1'b0;

      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
sv/lzsswd_pkg.sv
sv/lzsswd_window.sv
sv/lzss_window_decompressor_top.sv
sim/lzss_window_decompressor_top_tb.sv
